// ----- hw/rtl/fp4bsd_pkg.sv -----
`default_nettype none

package fp4bsd_pkg;

  // Block sum width, sized for the largest supported block (256 columns):
  // 256 * 12 * 128 = 393216 fits in 20 signed bits.
  localparam int SUM_W       = 20;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int ACC_W       = 64;

  localparam logic [7:0] SCALE_CODE_INF = 8'hFF;
  localparam logic [7:0] EXP_BASE_RESET = 8'd127;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic [7:0]        weight_pair;
    logic signed [7:0] activation_even;
    logic signed [7:0] activation_odd;
    logic [7:0]        block_scale_code;
    logic              row_end;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] row_total;
    logic                    saturated;
    logic                    infinite_scale;
  } out_item_t;

  // One closed block, handed from the front to the back.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [7:0]              code;
    logic                    last;
  } block_rec_t;

  // E2M1 code to doubled signed value: magnitudes 0,1,2,3,4,6,8,12.
  function automatic logic signed [4:0] fp4_value(input logic [3:0] code);
    logic [4:0] mag;
    begin
      case (code[2:0])
        3'd0:    mag = 5'd0;
        3'd1:    mag = 5'd1;
        3'd2:    mag = 5'd2;
        3'd3:    mag = 5'd3;
        3'd4:    mag = 5'd4;
        3'd5:    mag = 5'd6;
        3'd6:    mag = 5'd8;
        3'd7:    mag = 5'd12;
        default: mag = 5'd0;
      endcase
      fp4_value = code[3] ? -$signed(mag) : $signed(mag);
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fp4bsd_front.sv -----
`default_nettype none

module fp4bsd_front import fp4bsd_pkg::*; #(
  parameter int BLOCK_COLUMNS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire in_item_t   item,
  output      logic       push,
  output      block_rec_t rec
);

  localparam int PAIRS  = BLOCK_COLUMNS / 2;
  localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  logic signed [SUM_W-1:0]  block_sum_r, block_sum_nxt;
  logic [PAIR_W-1:0]        pair_cnt_r, pair_cnt_nxt;
  logic signed [12:0]       prod_even, prod_odd;
  logic signed [SUM_W-1:0]  sum_new;
  logic                     close;

  assign prod_even = 13'(fp4_value(item.weight_pair[3:0])) * 13'(item.activation_even);
  assign prod_odd  = 13'(fp4_value(item.weight_pair[7:4])) * 13'(item.activation_odd);
  assign sum_new   = block_sum_r + SUM_W'(prod_even) + SUM_W'(prod_odd);
  assign close     = item.row_end || (pair_cnt_r == PAIR_W'(PAIRS - 1));

  assign push      = accept && close;
  assign rec.sum   = sum_new;
  assign rec.code  = item.block_scale_code;
  assign rec.last  = item.row_end;

  always_comb begin
    block_sum_nxt = block_sum_r;
    pair_cnt_nxt  = pair_cnt_r;
    if (accept) begin
      if (close) begin
        block_sum_nxt = '0;
        pair_cnt_nxt  = '0;
      end else begin
        block_sum_nxt = sum_new;
        pair_cnt_nxt  = pair_cnt_r + PAIR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_sum_r <= '0;
      pair_cnt_r  <= '0;
    end else begin
      block_sum_r <= block_sum_nxt;
      pair_cnt_r  <= pair_cnt_nxt;
    end
  end

  a_pair_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pair_cnt_r <= PAIR_W'(PAIRS - 1))
    else $error("pair counter past block length");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (block_sum_r == '0) && (pair_cnt_r == '0))
    else $error("block state not cleared after close");

endmodule

`default_nettype wire

// ----- hw/rtl/fp4bsd_queue.sv -----
`default_nettype none

module fp4bsd_queue import fp4bsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire block_rec_t push_rec,
  input  wire logic       pop,
  output      block_rec_t head,
  output      logic       empty,
  output      logic       full
);

  block_rec_t               slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_PTR_W:0]     count_r, count_nxt;

  assign head  = slot_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + (QUEUE_PTR_W+1)'(1);
    else if (pop && !push) count_nxt = count_r - (QUEUE_PTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QUEUE_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QUEUE_PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- hw/rtl/fp4bsd_back.sv -----
`default_nettype none

module fp4bsd_back import fp4bsd_pkg::*; #(
  parameter int MAX_LEFT_SHIFT = 40
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] exp_base,
  input  wire block_rec_t head,
  input  wire logic       empty,
  output      logic       pop,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      out_item_t  out_data
);

  localparam int SHL_W = ACC_W + SUM_W;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic                    force_lim;
    logic                    neg;
    logic                    inf;
    logic                    last;
  } scaled_t;

  // Stage 1: scale the block sum.
  scaled_t                 s1_r, s1_nxt;
  logic                    s1_valid_r;
  logic                    s1_take, out_free;
  logic [SUM_W-1:0]        mag;
  logic signed [8:0]       shift;
  logic [7:0]              rshift;
  logic [SHL_W-1:0]        shl;

  // Stage 2: saturating accumulate.
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    inf_r, inf_nxt;
  logic signed [ACC_W:0]   add_wide;
  logic                    out_valid_r;
  out_item_t               out_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_take  = s1_valid_r && (!s1_r.last || out_free);
  assign pop      = !empty && (!s1_valid_r || s1_take);

  assign mag    = head.sum[SUM_W-1] ? SUM_W'(-head.sum) : SUM_W'(head.sum);
  assign shift  = $signed({1'b0, head.code}) - $signed({1'b0, exp_base});
  assign rshift = 8'(-shift);
  assign shl    = SHL_W'(mag) << shift[7:0];

  always_comb begin
    s1_nxt           = '0;
    s1_nxt.neg       = head.sum[SUM_W-1];
    s1_nxt.inf       = (head.code == SCALE_CODE_INF);
    s1_nxt.last      = head.last;
    if (head.sum != '0) begin
      if (s1_nxt.inf || (!shift[8] && (shift[7:0] > 8'(MAX_LEFT_SHIFT)))) begin
        s1_nxt.force_lim = 1'b1;
      end else if (!shift[8]) begin
        // anything at or above bit 63 does not fit a signed 64-bit value
        if (|shl[SHL_W-1:ACC_W-1]) begin
          s1_nxt.force_lim = 1'b1;
        end else if (s1_nxt.neg) begin
          s1_nxt.value = -$signed(shl[ACC_W-1:0]);
        end else begin
          s1_nxt.value = $signed(shl[ACC_W-1:0]);
        end
      end else begin
        // floor division by 2^r
        s1_nxt.value = ACC_W'(head.sum) >>> rshift;
      end
    end
  end

  assign add_wide = {acc_r[ACC_W-1], acc_r} + {s1_r.value[ACC_W-1], s1_r.value};

  always_comb begin
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    inf_nxt = inf_r || s1_r.inf;
    if (s1_r.force_lim) begin
      acc_nxt = s1_r.neg ? ACC_MIN : ACC_MAX;
      ovf_nxt = 1'b1;
    end else if (add_wide[ACC_W] != add_wide[ACC_W-1]) begin
      acc_nxt = add_wide[ACC_W] ? ACC_MIN : ACC_MAX;
      ovf_nxt = 1'b1;
    end else begin
      acc_nxt = add_wide[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) s1_r <= s1_nxt;
    if (s1_take && s1_r.last) begin
      out_r.row_total      <= acc_nxt;
      out_r.saturated      <= ovf_nxt;
      out_r.infinite_scale <= inf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      inf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) s1_valid_r <= 1'b1;
      else if (s1_take) s1_valid_r <= 1'b0;
      if (s1_take) begin
        if (s1_r.last) begin
          acc_r <= '0;
          ovf_r <= 1'b0;
          inf_r <= 1'b0;
        end else begin
          acc_r <= acc_nxt;
          ovf_r <= ovf_nxt;
          inf_r <= inf_nxt;
        end
      end
      if (s1_take && s1_r.last) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_row_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && s1_r.last) |=> (acc_r == '0) && !ovf_r && !inf_r)
    else $error("accumulator not cleared after row");

  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_r.last && out_valid_r && out_stall) |=> s1_valid_r)
    else $error("row result dropped while output stalled");

endmodule

`default_nettype wire

// ----- hw/rtl/fp4_block_scaled_dot.sv -----
// Block-scaled FP4 x int8 dot product, one row at a time.
//
// Input channel (in_valid / in_stall / in_data): one column pair per transfer,
// two E2M1 weight codes plus two int8 activations, the block scale code and a
// row_end mark. A transfer can occur every cycle; in_stall rises only when the
// block-close queue between front and back is full.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes exponent_base.
// cfg_ready is always high. Write only while no row is in flight.
// Output channel (out_valid / out_stall / out_data): one transfer per row with
// the saturated 64-bit row total and the overflow / infinite-scale flags.
// Throughput: one column pair per cycle while in_stall is low. Front decodes and
// sums each pair into a registered block sum; each block close goes through a
// queue into a two-stage back end (shift stage, saturating accumulate stage),
// which takes one block per cycle unless a row's final block waits on the output.
// After the row_end transfer, out_valid rises from the output register when it is free.
// Out stall: the result sits in the output register; the back end keeps
// absorbing non-final blocks and holds only the next row's final block, then
// the 4-entry queue fills and in_stall rises.
// Reset (rst_n low, synchronous): clears block sum, pair count, accumulator,
// flags, queue and valids; exponent_base returns to 127. No clearing pass.
`default_nettype none

module fp4_block_scaled_dot import fp4bsd_pkg::*; #(
  parameter int BLOCK_COLUMNS  = 32,
  parameter int MAX_LEFT_SHIFT = 40
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire in_item_t   in_data,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      out_item_t  out_data,
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] exp_base_val_r;
  logic       in_accept;
  logic       push, pop, q_empty, q_full;
  block_rec_t push_rec, head;

  // exponent_base register; back end reads it directly, so writes must happen
  // only while idle; the block itself does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_base_val_r <= EXP_BASE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) exp_base_val_r <= cfg_data;
    end
  end

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // front: decode, multiply, block sum, close detection
  fp4bsd_front #(
    .BLOCK_COLUMNS(BLOCK_COLUMNS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_data),
    .push   (push),
    .rec    (push_rec)
  );

  // decoupling queue of closed blocks
  fp4bsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back: scaling shift, saturating row accumulate, output register
  fp4bsd_back #(
    .MAX_LEFT_SHIFT(MAX_LEFT_SHIFT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .exp_base  (exp_base_val_r),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- verif/fp4_block_scaled_dot_test.sv -----
`timescale 1ns / 1ps

module fp4_block_scaled_dot_test;
  import fp4bsd_pkg::*;

  localparam int BLOCK_COLUMNS   = 32;
  localparam int MAX_SHIFT       = 40;
  localparam int PAIRS_PER_BLOCK = BLOCK_COLUMNS / 2;
  localparam int PHASE_PAIRS     = 300;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  fp4_block_scaled_dot #(
    .BLOCK_COLUMNS  (BLOCK_COLUMNS),
    .MAX_LEFT_SHIFT (MAX_SHIFT)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Column pairs waiting to be sent, and row totals waiting to come back.
  in_item_t  pair_queue[$];
  out_item_t expected_rows[$];

  // Idle percentages for the current phase (0..99 scale).
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Run bookkeeping.
  int errors         = 0;
  int pairs_sent     = 0;
  int rows_checked   = 0;
  int sat_rows       = 0;
  int inf_rows       = 0;
  int base_settings  = 1;

  // Predictor state: mirrors the datapath at transfer granularity.
  logic [7:0]              exp_base = EXP_BASE_RESET;
  longint                  pair_sum;
  int                      pairs_in_block;
  logic signed [ACC_W-1:0] row_acc;
  bit                      row_overflow;
  bit                      row_inf;

  // E2M1 doubled magnitudes, sign in bit 3.
  function automatic int e2m1_doubled(input logic [3:0] code);
    int mag_lut[8];
    mag_lut = '{0, 1, 2, 3, 4, 6, 8, 12};
    return code[3] ? -mag_lut[code[2:0]] : mag_lut[code[2:0]];
  endfunction

  task automatic pin_limit(input bit negative);
    row_acc      = negative ? ACC_MIN : ACC_MAX;
    row_overflow = 1'b1;
  endtask

  task automatic acc_add(input logic signed [ACC_W-1:0] addend);
    logic signed [ACC_W:0] wide;
    wide = row_acc + addend;
    if (wide > ACC_MAX) pin_limit(1'b0);
    else if (wide < ACC_MIN) pin_limit(1'b1);
    else row_acc = wide[ACC_W-1:0];
  endtask

  // Scale the finished block by 2^(code - base) and fold it into the row.
  task automatic close_block(input logic [7:0] code);
    bit                      neg;
    longint                  mag;
    int                      s;
    int                      r;
    logic signed [ACC_W-1:0] v;
    neg = pair_sum < 0;
    mag = neg ? -pair_sum : pair_sum;
    s   = int'(code) - int'(exp_base);
    if (code == SCALE_CODE_INF) row_inf = 1'b1;
    // an empty block adds nothing to the sum, though an infinite code still flags the row
    if (mag != 0) begin
      if (code == SCALE_CODE_INF || s > MAX_SHIFT) begin
        pin_limit(neg);
      end else if (s >= 0) begin
        if (s >= 63 || mag > (ACC_MAX >>> s)) pin_limit(neg);
        else acc_add(neg ? -(mag <<< s) : (mag <<< s));
      end else begin
        // right shift floors toward minus infinity
        r = -s;
        if (!neg) v = (r >= 63) ? 64'sd0 : (mag >> r);
        else v = (r >= 63) ? -64'sd1 : -((mag - 1) >> r) - 1;
        acc_add(v);
      end
    end
    pair_sum       = 0;
    pairs_in_block = 0;
  endtask

  // Fold one accepted column pair into the predicted row state.
  task automatic absorb_pair(input in_item_t it);
    out_item_t row;
    pair_sum += longint'(e2m1_doubled(it.weight_pair[3:0]) * int'(it.activation_even))
              + longint'(e2m1_doubled(it.weight_pair[7:4]) * int'(it.activation_odd));
    pairs_in_block++;
    if (it.row_end || pairs_in_block >= PAIRS_PER_BLOCK) close_block(it.block_scale_code);
    if (it.row_end) begin
      row.row_total      = row_acc;
      row.saturated      = row_overflow;
      row.infinite_scale = row_inf;
      expected_rows.insert(expected_rows.size(), row);
      sat_rows += row_overflow;
      inf_rows += row_inf;
      row_acc      = '0;
      row_overflow = 1'b0;
      row_inf      = 1'b0;
    end
  endtask

  task automatic check_row(input out_item_t got);
    out_item_t want;
    if (expected_rows.size() == 0) begin
      errors++;
      $display("%0t: row total with nothing expected: got %h", $time, got);
    end else begin
      want = expected_rows.pop_front();
      rows_checked++;
      if (got.row_total !== want.row_total) begin
        errors++;
        $display("%0t: row_total expected %0d got %0d", $time, want.row_total,
                 got.row_total);
      end
      if (got.saturated !== want.saturated) begin
        errors++;
        $display("%0t: saturated expected %0b got %0b", $time, want.saturated,
                 got.saturated);
      end
      if (got.infinite_scale !== want.infinite_scale) begin
        errors++;
        $display("%0t: infinite_scale expected %0b got %0b", $time,
                 want.infinite_scale, got.infinite_scale);
      end
    end
  endtask

  // Driver: predict on each transfer, then offer the next pair or go idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_pair(in_data);
        pairs_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pair_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pair_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor plus random back-pressure on the result side.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_row(out_data);
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  task automatic queue_pair(input logic [7:0] w, input logic signed [7:0] ae,
                            input logic signed [7:0] ao, input logic [7:0] code,
                            input logic last);
    in_item_t it;
    it.weight_pair      = w;
    it.activation_even  = ae;
    it.activation_odd   = ao;
    it.block_scale_code = code;
    it.row_end          = last;
    pair_queue.insert(pair_queue.size(), it);
  endtask

  // Block-end scale codes: mostly around the current base, sometimes past the
  // shift limit, infinite, or anything at all.
  function automatic logic [7:0] pick_scale();
    int c;
    case ($urandom_range(9))
      0: return SCALE_CODE_INF;
      1: return 8'($urandom_range(255));
      2: c = int'(exp_base) + $urandom_range(38, 46);
      default: c = int'(exp_base) + $urandom_range(90) - 50;
    endcase
    if (c < 0) c = 0;
    if (c > 254) c = 254;
    return 8'(c);
  endfunction

  // One row of random content; rows often span several blocks.
  task automatic queue_random_row(output int len);
    int k;
    bit block_end;
    len = ($urandom_range(3) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
    for (k = 0; k < len; k++) begin
      block_end = (k == len - 1) || ((k + 1) % PAIRS_PER_BLOCK == 0);
      queue_pair(8'($urandom), 8'($urandom), 8'($urandom),
                 block_end ? pick_scale() : 8'($urandom), k == len - 1);
    end
  endtask

  task automatic fill_random(input int pairs);
    int total;
    int len;
    total = 0;
    while (total < pairs) begin
      queue_random_row(len);
      total += len;
    end
  endtask

  // Sample at the falling edge so the driver's updates have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pair_queue.size() != 0 || in_valid || expected_rows.size() != 0);
  endtask

  task automatic write_base(input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    exp_base  = value;
    base_settings++;
  endtask

  task automatic run_phase(input logic [7:0] base, input int send_idle, input int stall);
    wait_drained();
    // rows all end in a result, but let the pipe empty before touching the base
    repeat (5) @(posedge clk);
    write_base(base);
    @(negedge clk);
    send_idle_pct = send_idle;
    stall_pct     = stall;
    fill_random(PHASE_PAIRS);
  endtask

  initial begin : stimulus
    int k;
    logic [3:0] lo;
    logic [3:0] hi;
    pair_sum       = 0;
    pairs_in_block = 0;
    row_acc        = '0;
    row_overflow   = 1'b0;
    row_inf        = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows at the reset base of 127.
    queue_pair(8'h00, 8'sd0, 8'sd0, SCALE_CODE_INF, 1'b1);   // empty sum, inf flag only
    queue_pair(8'hF7, 8'sd127, -8'sd128, 8'd168, 1'b1);       // one past the shift limit
    queue_pair(8'h77, 8'sd127, 8'sd127, 8'd167, 1'b1);        // exactly at the limit
    queue_pair(8'h09, 8'sd5, 8'sd0, 8'd0, 1'b1);              // deep right shift, negative: -1
    queue_pair(8'h01, 8'sd5, 8'sd0, 8'd0, 1'b1);              // deep right shift, positive: 0
    queue_pair(8'h0A, 8'sd3, 8'sd0, SCALE_CODE_INF, 1'b1);    // inf with nonzero sum
    // Full block over all 16 codes, pinned high past the limit, then a short
    // tail block whose add overflows the pinned accumulator.
    for (k = 0; k < PAIRS_PER_BLOCK; k++) begin
      lo = 4'(k);
      hi = 4'(15 - k);
      queue_pair({hi, lo}, lo[3] ? -8'sd128 : 8'sd127, hi[3] ? -8'sd127 : 8'sd127,
                 (k == PAIRS_PER_BLOCK - 1) ? 8'd168 : 8'($urandom), 1'b0);
    end
    queue_pair(8'h11, 8'sd1, 8'sd1, 8'd127, 1'b1);
    fill_random(PHASE_PAIRS);

    // Base extremes and a mid value, under each idle pattern.
    run_phase(8'd0, 55, 0);
    run_phase(8'd254, 0, 55);
    run_phase(8'($urandom_range(1, 253)), 19, 19);
    run_phase(EXP_BASE_RESET, 0, 0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_rows.size() != 0) begin
      errors++;
      $display("%0t: %0d row totals never arrived", $time, expected_rows.size());
    end
    $display("%0d column pairs sent, %0d row totals checked over %0d base settings",
             pairs_sent, rows_checked, base_settings);
    $display("%0d rows saturated, %0d rows saw an infinite block scale",
             sat_rows, inf_rows);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("%0t: timeout", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/fp4bsd_pkg.sv
hw/rtl/fp4bsd_front.sv
hw/rtl/fp4bsd_queue.sv
hw/rtl/fp4bsd_back.sv
hw/rtl/fp4_block_scaled_dot.sv
verif/fp4_block_scaled_dot_test.sv
